>>> design/cls_pkg.sv
// shared types and constants for the clamped linear scaler
`timescale 1ns / 1ps

package cls_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_START   = 3'd0,
        CFG_IN_END     = 3'd1,
        CFG_OUT_START  = 3'd2,
        CFG_OUT_END    = 3'd3,
        CFG_IN_OFFSET  = 3'd4,
        CFG_OUT_OFFSET = 3'd5
    } t_cfg_idx;

    // control bits that travel beside the data through the divider
    typedef struct packed {
        logic vld;
        logic neg;
    } t_div_tag;

endpackage

>>> design/cls_div.sv
// pipelined restoring divider, one quotient bit per register stage
`timescale 1ns / 1ps

module cls_div #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cls_pkg::t_div_tag         i_tag,
    input  logic [2*DATA_WIDTH-1:0]   i_dividend,
    input  logic [DATA_WIDTH-1:0]     i_divisor,
    output cls_pkg::t_div_tag         o_tag,
    output logic [2*DATA_WIDTH-1:0]   o_quotient
);

    localparam int DW = DATA_WIDTH;
    localparam int NS = 2 * DATA_WIDTH;

    logic [DW-1:0]     r_rem [NS];
    logic [NS-1:0]     r_num [NS];
    cls_pkg::t_div_tag r_tag [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [DW-1:0]     w_rem_in;
        logic [NS-1:0]     w_num_in;
        cls_pkg::t_div_tag w_tag_in;
        logic [DW:0]       w_trial;
        logic [DW:0]       w_diff;
        logic              w_ge;
        logic [DW-1:0]     n_rem;
        logic [NS-1:0]     n_num;

        if (k == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_num_in = i_dividend;
            assign w_tag_in = i_tag;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_num_in = r_num[k-1];
            assign w_tag_in = r_tag[k-1];
        end

        // quotient bits shift in at the bottom as dividend bits leave the top
        always_comb begin
            w_trial = {w_rem_in, w_num_in[NS-1]};
            w_diff  = w_trial - {1'b0, i_divisor};
            w_ge    = (w_trial >= {1'b0, i_divisor});
            n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            n_num   = {w_num_in[NS-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k] <= '0;
            end else begin
                r_tag[k] <= w_tag_in;
            end
            r_rem[k] <= n_rem;
            r_num[k] <= n_num;
        end
    end

    assign o_tag      = r_tag[NS-1];
    assign o_quotient = r_num[NS-1];

endmodule

>>> design/clamped_linear_scaler.sv
// top level of the clamped linear scaler
`timescale 1ns / 1ps

// Maps a signed sample from an input range onto an output range with clamps.
// Input: a beat is taken at a clock edge where start is high and busy is low;
// the sample sits on i_raw_sample at that edge.
// Output: o_valid is high for exactly one cycle with o_scaled_value; the
// receiver cannot stall, so results are shown once and never held.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 in_start,
// 1 in_end, 2 out_start, 3 out_end, 4 in_offset, 5 out_offset); other indexes
// are ignored. Write registers only while no beat is in flight.
// Throughput: one beat per cycle whenever busy is low.
// Pipeline: input offset, input clamp, product, the divider with one stage per
// quotient bit, sign and output base add, and output clamp, each registered in
// turn from the accepting edge to the edge that registers the result.
// Reset: synchronous, clears all valid bits and loads the register defaults;
// busy stays high for one cycle after reset is released.

module clamped_linear_scaler #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [DATA_WIDTH-1:0]   i_raw_sample,
    output logic                           o_valid,
    output logic signed [DATA_WIDTH-1:0]   o_scaled_value,
    input  logic                           i_cfg_we,
    input  logic [cls_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]          i_cfg_data
);

    localparam int DW = DATA_WIDTH;
    localparam int QW = 2 * DATA_WIDTH;
    localparam int SW = 2 * DATA_WIDTH + 2;

    // configuration registers
    logic signed [DW-1:0] r_in_start;
    logic signed [DW-1:0] r_in_end;
    logic signed [DW-1:0] r_out_start;
    logic signed [DW-1:0] r_out_end;
    logic signed [DW-1:0] r_in_offset;
    logic signed [DW-1:0] r_out_offset;

    // values derived from configuration, static while beats are in flight
    logic [DW-1:0]        r_ir_mag;
    logic                 r_ir_neg;
    logic                 r_ir_zero;
    logic [DW-1:0]        r_or_mag;
    logic                 r_or_neg;
    logic signed [DW:0]   r_out_base;

    logic                 r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_start   <= '0;
            r_in_end     <= {1'b0, {(DW-1){1'b1}}};
            r_out_start  <= '0;
            r_out_end    <= {1'b0, {(DW-1){1'b1}}};
            r_in_offset  <= '0;
            r_out_offset <= '0;
            r_busy       <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (cls_pkg::t_cfg_idx'(i_cfg_idx))
                    cls_pkg::CFG_IN_START:   r_in_start   <= i_cfg_data;
                    cls_pkg::CFG_IN_END:     r_in_end     <= i_cfg_data;
                    cls_pkg::CFG_OUT_START:  r_out_start  <= i_cfg_data;
                    cls_pkg::CFG_OUT_END:    r_out_end    <= i_cfg_data;
                    cls_pkg::CFG_IN_OFFSET:  r_in_offset  <= i_cfg_data;
                    cls_pkg::CFG_OUT_OFFSET: r_out_offset <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign busy = r_busy;

    logic signed [DW:0] w_ir;
    logic signed [DW:0] w_or;
    logic signed [DW:0] w_ir_abs;
    logic signed [DW:0] w_or_abs;

    always_comb begin
        w_ir     = {r_in_end[DW-1], r_in_end} - {r_in_start[DW-1], r_in_start};
        w_or     = {r_out_end[DW-1], r_out_end} - {r_out_start[DW-1], r_out_start};
        w_ir_abs = w_ir[DW] ? -w_ir : w_ir;
        w_or_abs = w_or[DW] ? -w_or : w_or;
    end

    always_ff @(posedge i_clk) begin
        r_ir_mag   <= w_ir_abs[DW-1:0];
        r_ir_neg   <= w_ir[DW];
        r_ir_zero  <= (w_ir == '0);
        r_or_mag   <= w_or_abs[DW-1:0];
        r_or_neg   <= w_or[DW];
        r_out_base <= {r_out_start[DW-1], r_out_start} + {r_out_offset[DW-1], r_out_offset};
    end

    // stage 1: add the input offset
    logic                 r_p1_vld;
    logic signed [DW:0]   r_p1_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= start && !r_busy;
        end
        r_p1_x <= {i_raw_sample[DW-1], i_raw_sample} + {r_in_offset[DW-1], r_in_offset};
    end

    // stage 2: input clamp, distance from the range start and its magnitude
    logic signed [DW:0]   w_ia;
    logic signed [DW:0]   w_ib;
    logic signed [DW:0]   w_xc;
    logic signed [DW:0]   w_d;
    logic signed [DW:0]   w_d_abs;
    logic                 r_p2_vld;
    logic [DW-1:0]        r_p2_dmag;
    logic                 r_p2_neg;

    always_comb begin
        w_ia = {r_in_start[DW-1], r_in_start};
        w_ib = {r_in_end[DW-1], r_in_end};
        w_xc = r_p1_x;
        if (w_ia < w_ib) begin
            if (r_p1_x <= w_ia) begin
                w_xc = w_ia;
            end else if (r_p1_x >= w_ib) begin
                w_xc = w_ib;
            end
        end else begin
            if (r_p1_x >= w_ia) begin
                w_xc = w_ia;
            end else if (r_p1_x <= w_ib) begin
                w_xc = w_ib;
            end
        end
        w_d     = w_xc - w_ia;
        w_d_abs = w_d[DW] ? -w_d : w_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else begin
            r_p2_vld <= r_p1_vld;
        end
        r_p2_dmag <= w_d_abs[DW-1:0];
        r_p2_neg  <= w_d[DW] ^ r_or_neg ^ r_ir_neg;
    end

    // stage 3: unsigned product of the magnitudes
    logic                 r_p3_vld;
    logic                 r_p3_neg;
    logic [QW-1:0]        r_p3_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else begin
            r_p3_vld <= r_p2_vld;
        end
        r_p3_neg  <= r_p2_neg;
        r_p3_prod <= {{DW{1'b0}}, r_p2_dmag} * {{DW{1'b0}}, r_or_mag};
    end

    cls_pkg::t_div_tag w_div_in_tag;
    cls_pkg::t_div_tag w_div_out_tag;
    logic [QW-1:0]     w_quot;

    assign w_div_in_tag.vld = r_p3_vld;
    assign w_div_in_tag.neg = r_p3_neg;

    cls_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (w_div_in_tag),
        .i_dividend (r_p3_prod),
        .i_divisor  (r_ir_mag),
        .o_tag      (w_div_out_tag),
        .o_quotient (w_quot)
    );

    // stage 4: apply the sign and add out_start plus out_offset
    logic                 r_p4_vld;
    logic signed [SW-1:0] r_p4_sum;
    logic [SW-1:0]        w_q_ext;

    assign w_q_ext = {2'b00, w_quot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_vld <= 1'b0;
        end else begin
            r_p4_vld <= w_div_out_tag.vld;
        end
        // conditional negate folded into the add as invert plus carry in
        r_p4_sum <= (w_q_ext ^ {SW{w_div_out_tag.neg}})
                  + {{(SW-DW-1){r_out_base[DW]}}, r_out_base}
                  + {{(SW-1){1'b0}}, w_div_out_tag.neg};
    end

    // stage 5: output clamp, or the flat range bypass
    logic signed [SW-1:0] w_oa;
    logic signed [SW-1:0] w_ob;
    logic signed [SW-1:0] w_res;
    logic                 r_out_vld;
    logic signed [DW-1:0] r_out_val;

    always_comb begin
        w_oa  = {{(SW-DW){r_out_start[DW-1]}}, r_out_start};
        w_ob  = {{(SW-DW){r_out_end[DW-1]}}, r_out_end};
        w_res = r_p4_sum;
        if (w_oa < w_ob) begin
            if (r_p4_sum <= w_oa) begin
                w_res = w_oa;
            end else if (r_p4_sum >= w_ob) begin
                w_res = w_ob;
            end
        end else begin
            if (r_p4_sum >= w_oa) begin
                w_res = w_oa;
            end else if (r_p4_sum <= w_ob) begin
                w_res = w_ob;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_p4_vld;
        end
        r_out_val <= r_ir_zero ? r_out_base[DW-1:0] : w_res[DW-1:0];
    end

    assign o_valid        = r_out_vld;
    assign o_scaled_value = r_out_val;

endmodule

>>> design/cls_chk.sv
// port-level checker for the clamped linear scaler and its bind
`timescale 1ns / 1ps

module cls_chk #(
    parameter int DATA_WIDTH = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    localparam int LAT = 2 * DATA_WIDTH + 5;

    // every accepted beat shows its result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result missing after accepted beat");

    // no result without a beat accepted the latency earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without an accepted beat");

    // reset leaves nothing in flight
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result right after reset");

    // the pipeline never pushes back once out of reset
    a_never_busy: assert property (@(posedge i_clk)
        ($past(i_rst_n) && i_rst_n) |-> !busy)
        else $error("busy raised outside reset");

endmodule

bind clamped_linear_scaler cls_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_cls_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

>>> bench/clamped_linear_scaler_tb.sv
// self-checking testbench for the clamped linear scaler
`timescale 1ns / 1ps

module clamped_linear_scaler_tb;

    localparam int DW          = 16;
    localparam int LATENCY     = 2 * DW + 4;
    localparam int TOTAL_ITEMS = 1450;
    localparam int QUIET_TAIL  = 220;
    localparam int CYCLE_LIMIT = 120000;

    // indexes past the last register, writes there must be ignored
    localparam logic [cls_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [cls_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef logic signed [DW-1:0] t_reg_set [6];

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic signed [DW-1:0]          i_raw_sample;
    logic                          o_valid;
    logic signed [DW-1:0]          o_scaled_value;
    logic                          i_cfg_we;
    logic [cls_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [DW-1:0]                 i_cfg_data;

    class scaled_value_tracker;
        logic signed [DW-1:0] regs [6];
        logic signed [DW-1:0] pending_scaled [$];
        int errors;
        int n_checked;

        function new();
            regs[cls_pkg::CFG_IN_START]   = 16'sd0;
            regs[cls_pkg::CFG_IN_END]     = 16'sd32767;
            regs[cls_pkg::CFG_OUT_START]  = 16'sd0;
            regs[cls_pkg::CFG_OUT_END]    = 16'sd32767;
            regs[cls_pkg::CFG_IN_OFFSET]  = 16'sd0;
            regs[cls_pkg::CFG_OUT_OFFSET] = 16'sd0;
            errors    = 0;
            n_checked = 0;
        endfunction

        function void write_reg(logic [cls_pkg::CFG_IDX_W-1:0] idx,
                                logic [DW-1:0] data);
            if (idx <= cls_pkg::CFG_OUT_OFFSET) regs[idx] = data;
        endfunction

        function int pending();
            return pending_scaled.size();
        endfunction

        static function longint clamp_between(longint v, longint a, longint b);
            if (a < b) begin
                if (v <= a) return a;
                if (v >= b) return b;
            end else begin
                if (v >= a) return a;
                if (v <= b) return b;
            end
            return v;
        endfunction

        static function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function logic signed [DW-1:0] scale_sample(logic signed [DW-1:0] raw);
            longint in_a, in_b, out_a, out_b, out_off;
            longint x, span_in, span_out, dx, mag_q, res;
            bit flip;
            in_a    = regs[cls_pkg::CFG_IN_START];
            in_b    = regs[cls_pkg::CFG_IN_END];
            out_a   = regs[cls_pkg::CFG_OUT_START];
            out_b   = regs[cls_pkg::CFG_OUT_END];
            out_off = regs[cls_pkg::CFG_OUT_OFFSET];
            x = longint'(raw) + longint'(regs[cls_pkg::CFG_IN_OFFSET]);
            x = clamp_between(x, in_a, in_b);
            span_in = in_b - in_a;
            // flat input range: no mapping and no output clamp, just wrap
            if (span_in == 0) return DW'(out_a + out_off);
            span_out = out_b - out_a;
            dx       = x - in_a;
            mag_q    = magnitude(dx) * magnitude(span_out) / magnitude(span_in);
            flip     = ((dx < 0) != (span_out < 0)) != (span_in < 0);
            res      = (flip ? -mag_q : mag_q) + out_a + out_off;
            return DW'(clamp_between(res, out_a, out_b));
        endfunction

        function void note_sample(logic signed [DW-1:0] raw);
            pending_scaled.push_back(scale_sample(raw));
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_scaled(logic signed [DW-1:0] got);
            logic signed [DW-1:0] want;
            n_checked++;
            if (pending_scaled.size() == 0) begin
                report($sformatf("result %0d arrived with nothing outstanding", got));
            end else begin
                want = pending_scaled.pop_front();
                if (got !== want)
                    report($sformatf("scaled_value got %0d want %0d", got, want));
            end
        endtask
    endclass

    scaled_value_tracker sb;
    int n_sent;
    int n_cfg_writes;
    int n_spare_writes;
    int n_settings;
    int cycle_count;

    clamped_linear_scaler #(
        .DATA_WIDTH(DW)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_raw_sample   (i_raw_sample),
        .o_valid        (o_valid),
        .o_scaled_value (o_scaled_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (o_valid === 1'b1) sb.check_scaled(o_scaled_value);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("clamped_linear_scaler_tb NOT OK");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [DW-1:0] v);
        @(negedge i_clk);
        start        <= 1'b1;
        i_raw_sample <= v;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_sample(v);
        n_sent++;
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // hold the sender off until every beat in flight has come out
    task automatic drain_results();
        idle_cycles(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic drive_reg(input logic [cls_pkg::CFG_IDX_W-1:0] idx,
                             input logic [DW-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        n_cfg_writes++;
        if (idx > cls_pkg::CFG_OUT_OFFSET) n_spare_writes++;
    endtask

    task automatic load_settings(input t_reg_set vals, input bit poke_spare);
        for (int i = 0; i < 6; i++) begin
            if (poke_spare && i == 3)
                drive_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                          DW'($urandom_range(0, 65535)));
            drive_reg(cls_pkg::CFG_IDX_W'(i), vals[i]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic logic signed [DW-1:0] pick_reg_value();
        logic signed [DW-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'sh8000;
            1:       v = 16'sh7fff;
            2:       v = 16'sd0;
            3, 4:    v = DW'($urandom_range(0, 400) - 200);
            default: v = DW'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic t_reg_set pick_settings();
        t_reg_set v;
        for (int i = 0; i < 6; i++) v[i] = pick_reg_value();
        if ($urandom_range(0, 9) == 0)
            v[cls_pkg::CFG_IN_END] = v[cls_pkg::CFG_IN_START];
        if ($urandom_range(0, 9) == 0)
            v[cls_pkg::CFG_OUT_END] = v[cls_pkg::CFG_OUT_START];
        return v;
    endfunction

    // bias samples toward the input bounds once the offset is taken out
    function automatic logic signed [DW-1:0] pick_raw();
        longint base;
        longint jitter;
        jitter = longint'(int'($urandom_range(0, 80)) - 40);
        base   = -longint'(sb.regs[cls_pkg::CFG_IN_OFFSET]);
        case ($urandom_range(0, 9))
            4, 5:    return DW'(base + sb.regs[cls_pkg::CFG_IN_START] + jitter);
            6, 7:    return DW'(base + sb.regs[cls_pkg::CFG_IN_END] + jitter);
            8:       return DW'(base
                                + (longint'(sb.regs[cls_pkg::CFG_IN_START])
                                   + sb.regs[cls_pkg::CFG_IN_END]) / 2
                                + jitter);
            9:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return DW'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        int phase_len;
        int idle_rate;
        bit tail_phase;
        sb             = new();
        n_sent         = 0;
        n_cfg_writes   = 0;
        n_spare_writes = 0;
        n_settings     = 0;
        cycle_count    = 0;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_raw_sample   = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults after reset
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(16'sh7fff);

        // full input span onto an inverted full output span, wide product
        drain_results();
        load_settings('{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd0, 16'sd0}, 1'b0);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sd0);

        // inverted input range with offsets at their extremes
        drain_results();
        load_settings('{16'sd1000, -16'sd1000, -16'sd500, 16'sd500, 16'sh7fff, 16'sh8000},
                      1'b0);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sd0);

        // flat input range, the output sum wraps with no clamp
        drain_results();
        load_settings('{16'sd5, 16'sd5, 16'sh7fff, -16'sd3, 16'sd0, 16'sd1}, 1'b0);
        send_sample(16'sd0);
        send_sample(16'sh7fff);

        // flat output range pins the result to out_start
        drain_results();
        load_settings('{-16'sd100, 16'sd100, 16'sd7, 16'sd7, 16'sd0, 16'sd900}, 1'b0);
        send_sample(-16'sd100);
        send_sample(16'sd50);

        // writes to the unused indexes must leave these settings alone
        drain_results();
        load_settings('{16'sd0, 16'sd10, -16'sd10, 16'sd10, 16'sh8000, 16'sh7fff}, 1'b1);
        drive_reg(CFG_SPARE_LO, 16'hffff);
        drive_reg(CFG_SPARE_HI, 16'hffff);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        send_sample(-16'sd1);
        send_sample(16'sh7fff);

        while (n_sent < TOTAL_ITEMS) begin
            drain_results();
            load_settings(pick_settings(), $urandom_range(0, 6) == 0);
            tail_phase = (TOTAL_ITEMS - n_sent) <= QUIET_TAIL;
            phase_len  = tail_phase ? TOTAL_ITEMS - n_sent : $urandom_range(20, 70);
            idle_rate  = tail_phase ? 0 : $urandom_range(0, 3);
            for (int k = 0; k < phase_len && n_sent < TOTAL_ITEMS; k++) begin
                send_sample(pick_raw());
                if ($urandom_range(0, 9) < idle_rate) idle_cycles($urandom_range(1, 7));
            end
        end

        idle_cycles(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("covered %0d samples under %0d register settings, %0d register writes",
                 n_sent, n_settings, n_cfg_writes);
        $display("(%0d to unused indexes), %0d results compared, %0d mismatches",
                 n_spare_writes, sb.n_checked, sb.errors);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never came", sb.pending()));
        if (sb.errors == 0) begin
            $display("clamped_linear_scaler_tb OK");
        end else begin
            $display("clamped_linear_scaler_tb NOT OK");
        end
        $finish;
    end

endmodule
